// ----- rtl/qclr_pkg.sv -----
`default_nettype none

package qclr_pkg;

  // fixed-point format of the coordinates
  localparam int FRAC_BITS   = 20;
  localparam int COORD_WIDTH = 32;

  localparam int LON_IN_W  = 30;
  localparam int PERIOD_W  = 29;
  localparam int NCORNER   = 4;

  // register map, word index = paddr[3:2]
  localparam logic [1:0] REG_PERIOD  = 2'd0;
  localparam logic [1:0] REG_FIX     = 2'd1;
  localparam logic [1:0] REG_AVERAGE = 2'd2;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(64'd360 << FRAC_BITS);

  // ceil(2^33 / 3): exact floor(x / 3) for any 32-bit x via (x * RECIP3) >> 33
  localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;

  // working width of the shift arithmetic, wide enough for d +/- period
  typedef logic signed [34:0] wide_t;
  typedef logic signed [30:0] lon1_t;   // after the first dateline pass
  typedef logic signed [31:0] lon2_t;   // after pole averaging

  function automatic wide_t abs_w(input wide_t v);
    abs_w = v[34] ? -v : v;
  endfunction

  // move lon by -p, 0 or +p toward base, only where strictly closer
  function automatic wide_t shift_toward(input wide_t p, input wide_t base,
                                         input wide_t lon);
    wide_t d;
    wide_t best;
    wide_t dm;
    wide_t dp;
    wide_t res;
    d    = lon - base;
    best = abs_w(d);
    dm   = abs_w(d - p);
    dp   = abs_w(d + p);
    res  = lon;
    if (dm < best) begin
      best = dm;
      res  = lon - p;
    end
    if (dp < best) begin
      res = lon + p;
    end
    shift_toward = res;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/quad_cell_longitude_regularizer_core.sv -----
`default_nettype none

// Channel   Handshake                  Payload
// item      item_valid / item_stall    lon_0..lon_3, lat_0..lat_3 (30 bit signed)
// result    result_valid / result_stall out_lon_0..3 (COORD_WIDTH signed),
//                                      pole_found, all_corners_pole
// config    APB: psel penable pwrite paddr pwdata prdata pready
//
// One word per cycle sustained while result_stall stays low. Five register
// stages: first dateline pass + pole test, non-pole sum, divide-by-3
// multiply, mean select + pole replace, second dateline pass into the
// output register.
// rst is synchronous; it clears the stage valid bits and reloads the config
// registers with their reset values.
// A stall on the result side backs up stage by stage; each stage holds its
// word until the next one frees up, so nothing is dropped or repeated.

module quad_cell_longitude_regularizer_core #(
  parameter int COORD_WIDTH = qclr_pkg::COORD_WIDTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst,

  input  wire logic                          item_valid,
  output logic                               item_stall,
  input  wire logic signed [29:0]            lon_0,
  input  wire logic signed [29:0]            lon_1,
  input  wire logic signed [29:0]            lon_2,
  input  wire logic signed [29:0]            lon_3,
  input  wire logic signed [29:0]            lat_0,
  input  wire logic signed [29:0]            lat_1,
  input  wire logic signed [29:0]            lat_2,
  input  wire logic signed [29:0]            lat_3,

  output logic                               result_valid,
  input  wire logic                          result_stall,
  output logic signed [COORD_WIDTH-1:0]      out_lon_0,
  output logic signed [COORD_WIDTH-1:0]      out_lon_1,
  output logic signed [COORD_WIDTH-1:0]      out_lon_2,
  output logic signed [COORD_WIDTH-1:0]      out_lon_3,
  output logic                               pole_found,
  output logic                               all_corners_pole,

  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [3:0]                    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  // ---------------------------------------------------------------- config
  logic [qclr_pkg::PERIOD_W-1:0] period;
  logic                          fix_dateline;
  logic                          average_at_pole;
  logic                          cfg_wr;
  logic [1:0]                    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      period          <= qclr_pkg::PERIOD_RESET;
      fix_dateline    <= 1'b1;
      average_at_pole <= 1'b1;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        qclr_pkg::REG_PERIOD:  period          <= pwdata[qclr_pkg::PERIOD_W-1:0];
        qclr_pkg::REG_FIX:     fix_dateline    <= pwdata[0];
        qclr_pkg::REG_AVERAGE: average_at_pole <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      qclr_pkg::REG_PERIOD:  prdata = {3'b000, period};
      qclr_pkg::REG_FIX:     prdata = {31'd0, fix_dateline};
      qclr_pkg::REG_AVERAGE: prdata = {31'd0, average_at_pole};
      default:               prdata = 32'd0;
    endcase
  end

  qclr_pkg::wide_t p_w;
  assign p_w = qclr_pkg::wide_t'({1'b0, period});

  // ---------------------------------------------------------- flow control
  logic va, vb, vc, vd;
  logic ready_a, ready_b, ready_c, ready_d, ready_e;

  assign ready_e    = !result_valid || !result_stall;
  assign ready_d    = !vd || ready_e;
  assign ready_c    = !vc || ready_d;
  assign ready_b    = !vb || ready_c;
  assign ready_a    = !va || ready_b;
  assign item_stall = !ready_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      va           <= 1'b0;
      vb           <= 1'b0;
      vc           <= 1'b0;
      vd           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (ready_a) va           <= item_valid;
      if (ready_b) vb           <= va;
      if (ready_c) vc           <= vb;
      if (ready_d) vd           <= vc;
      if (ready_e) result_valid <= vd;
    end
  end

  // ------------------------------------- stage A: first pass and pole test
  logic signed [29:0]  lon_in [qclr_pkg::NCORNER];
  logic signed [29:0]  lat_in [qclr_pkg::NCORNER];
  qclr_pkg::lon1_t     lon_a_next [qclr_pkg::NCORNER];
  logic [3:0]          pole_a_next;
  qclr_pkg::lon1_t     lon_a [qclr_pkg::NCORNER];
  logic [3:0]          pole_a;

  assign lon_in[0] = lon_0;
  assign lon_in[1] = lon_1;
  assign lon_in[2] = lon_2;
  assign lon_in[3] = lon_3;
  assign lat_in[0] = lat_0;
  assign lat_in[1] = lat_1;
  assign lat_in[2] = lat_2;
  assign lat_in[3] = lat_3;

  always_comb begin
    qclr_pkg::wide_t base;
    qclr_pkg::wide_t lo;
    qclr_pkg::wide_t sh;
    logic [29:0]     abs_lat;
    base = qclr_pkg::wide_t'(lon_in[0]);
    for (int i = 0; i < qclr_pkg::NCORNER; i++) begin
      lo = qclr_pkg::wide_t'(lon_in[i]);
      sh = fix_dateline ? qclr_pkg::shift_toward(p_w, base, lo) : lo;
      lon_a_next[i] = qclr_pkg::lon1_t'(sh);
      // pole when 4*|lat| equals the period exactly
      abs_lat = lat_in[i][29] ? 30'(-lat_in[i]) : 30'(lat_in[i]);
      pole_a_next[i] = ({abs_lat, 2'b00} == {3'b000, period});
    end
  end

  always_ff @(posedge clk) begin
    if (ready_a && item_valid) begin
      lon_a  <= lon_a_next;
      pole_a <= pole_a_next;
    end
  end

  // ----------------------------------------- stage B: sum of non-pole lons
  qclr_pkg::lon1_t lon_b [qclr_pkg::NCORNER];
  logic [1:0]      pidx_b;
  logic            pfound_b;
  logic [2:0]      count_b;
  logic            neg_b;
  logic [31:0]     abs_b;

  logic [1:0]         pidx_b_next;
  logic [2:0]         count_b_next;
  logic signed [33:0] sum_b_next;

  always_comb begin
    logic signed [33:0] mv [qclr_pkg::NCORNER];
    for (int i = 0; i < qclr_pkg::NCORNER; i++) begin
      mv[i] = pole_a[i] ? 34'sd0 : 34'(lon_a[i]);
    end
    sum_b_next   = (mv[0] + mv[1]) + (mv[2] + mv[3]);
    count_b_next = 3'(!pole_a[0]) + 3'(!pole_a[1]) + 3'(!pole_a[2]) + 3'(!pole_a[3]);
    // last pole corner wins
    if (pole_a[3])      pidx_b_next = 2'd3;
    else if (pole_a[2]) pidx_b_next = 2'd2;
    else if (pole_a[1]) pidx_b_next = 2'd1;
    else                pidx_b_next = 2'd0;
  end

  always_ff @(posedge clk) begin
    if (ready_b && va) begin
      lon_b    <= lon_a;
      pidx_b   <= pidx_b_next;
      pfound_b <= |pole_a;
      count_b  <= count_b_next;
      neg_b    <= sum_b_next[33];
      // magnitude stays below 3*2^30 whenever the mean is used
      abs_b    <= sum_b_next[33] ? 32'(-sum_b_next) : 32'(sum_b_next);
    end
  end

  // -------------------------------------------- stage C: divide-by-3 multiply
  qclr_pkg::lon1_t lon_c [qclr_pkg::NCORNER];
  logic [1:0]      pidx_c;
  logic            pfound_c;
  logic [2:0]      count_c;
  logic            neg_c;
  logic [31:0]     abs_c;
  logic [63:0]     prod_c;

  always_ff @(posedge clk) begin
    if (ready_c && vb) begin
      lon_c    <= lon_b;
      pidx_c   <= pidx_b;
      pfound_c <= pfound_b;
      count_c  <= count_b;
      neg_c    <= neg_b;
      abs_c    <= abs_b;
      prod_c   <= 64'(abs_b) * 64'(qclr_pkg::RECIP3);
    end
  end

  // ------------------------------------- stage D: mean and pole replacement
  qclr_pkg::lon2_t lon_d [qclr_pkg::NCORNER];
  logic            pfound_d;
  logic            allp_d;
  qclr_pkg::lon2_t lon_d_next [qclr_pkg::NCORNER];
  logic            allp_c;

  assign allp_c = (count_c == 3'd0);

  always_comb begin
    logic [31:0]     q;
    qclr_pkg::lon2_t mean;
    case (count_c)
      3'd3:    q = {1'b0, prod_c[63:33]};
      3'd2:    q = abs_c >> 1;
      default: q = abs_c;
    endcase
    // truncate toward zero: divide the magnitude, restore the sign
    mean = neg_c ? -qclr_pkg::lon2_t'(q) : qclr_pkg::lon2_t'(q);
    for (int i = 0; i < qclr_pkg::NCORNER; i++) begin
      if (average_at_pole && pfound_c && !allp_c && (pidx_c == 2'(i)))
        lon_d_next[i] = mean;
      else
        lon_d_next[i] = qclr_pkg::lon2_t'(lon_c[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (ready_d && vc) begin
      lon_d    <= lon_d_next;
      pfound_d <= pfound_c;
      allp_d   <= allp_c;
    end
  end

  // --------------------------- stage E: second pass into the output register
  qclr_pkg::wide_t lon_e_next [qclr_pkg::NCORNER];

  always_comb begin
    qclr_pkg::wide_t base;
    qclr_pkg::wide_t lo;
    base          = qclr_pkg::wide_t'(lon_d[0]);
    lon_e_next[0] = base;
    for (int i = 1; i < qclr_pkg::NCORNER; i++) begin
      lo = qclr_pkg::wide_t'(lon_d[i]);
      lon_e_next[i] = fix_dateline ? qclr_pkg::shift_toward(p_w, base, lo) : lo;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_e && vd) begin
      out_lon_0        <= COORD_WIDTH'(lon_e_next[0]);
      out_lon_1        <= COORD_WIDTH'(lon_e_next[1]);
      out_lon_2        <= COORD_WIDTH'(lon_e_next[2]);
      out_lon_3        <= COORD_WIDTH'(lon_e_next[3]);
      pole_found       <= pfound_d;
      all_corners_pole <= allp_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/qclr_checker.sv -----
`default_nettype none

module qclr_checker #(
  parameter int COORD_WIDTH = qclr_pkg::COORD_WIDTH
) (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          item_stall,
  input wire logic                          result_valid,
  input wire logic                          result_stall,
  input wire logic signed [COORD_WIDTH-1:0] out_lon_0,
  input wire logic                          pole_found,
  input wire logic                          all_corners_pole
);

  // input only backs up behind a held result word
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (result_valid && result_stall))
    else $error("item_stall without a stalled result word");

  // all-pole cell is a pole cell
  a_flags: assert property (@(posedge clk) disable iff (rst)
    (result_valid && all_corners_pole) |-> pole_found)
    else $error("all_corners_pole without pole_found");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result word present after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(out_lon_0)))
    else $error("stalled result word changed");

endmodule

bind quad_cell_longitude_regularizer_core qclr_checker #(
  .COORD_WIDTH(COORD_WIDTH)
) u_qclr_checker (
  .clk             (clk),
  .rst             (rst),
  .item_stall      (item_stall),
  .result_valid    (result_valid),
  .result_stall    (result_stall),
  .out_lon_0       (out_lon_0),
  .pole_found      (pole_found),
  .all_corners_pole(all_corners_pole)
);

`default_nettype wire

// ----- verif/tb_top.sv -----
`default_nettype none

// Testbench for quad_cell_longitude_regularizer_core.
// The sender pushes one cell (four lon/lat corners) per word and a golden
// model below predicts the four regularized longitudes and the two pole
// flags at the moment the word is accepted. A checker pops the prediction
// when the result word is accepted and compares it field by field.
// Registers are changed only with the pipe drained.
module tb_top;

  localparam int  PIPE_DEPTH  = 4;               // accept to result_valid
  localparam longint DEG      = 64'd1 << qclr_pkg::FRAC_BITS;
  localparam longint LON_MAX  = (64'd1 << 29) - 1;
  localparam longint LON_MIN  = -(64'sd1 << 29);
  localparam longint PERIOD_2PI = 6588397;       // 2*pi in q.20
  localparam int  RAND_PHASES = 8;
  localparam int  PHASE_WORDS = 210;
  localparam int  MAX_REPORTS = 10;

  // one input word: corner k lives in lon[k] / lat[k]
  typedef struct packed {
    logic [3:0][29:0] lon;
    logic [3:0][29:0] lat;
  } cell_in_t;

  // one result word
  typedef struct packed {
    logic [3:0][31:0] lon;
    logic             pole;
    logic             all_pole;
  } cell_out_t;

  logic clk;
  logic rst = 1'b1;

  logic        item_valid = 1'b0;
  logic        item_stall;
  logic [29:0] lon_0 = '0, lon_1 = '0, lon_2 = '0, lon_3 = '0;
  logic [29:0] lat_0 = '0, lat_1 = '0, lat_2 = '0, lat_3 = '0;

  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [31:0] out_lon_0, out_lon_1, out_lon_2, out_lon_3;
  logic        pole_found, all_corners_pole;

  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // shadow copy of the register file, kept in step with every APB write
  logic [qclr_pkg::PERIOD_W-1:0] cfg_period = qclr_pkg::PERIOD_RESET;
  logic                          cfg_fix    = 1'b1;
  logic                          cfg_avg    = 1'b1;

  cell_out_t predicted_cells[$];
  int        mismatch_count = 0;

  // idle pressure in percent per opportunity; zero turns a side quiet
  int send_gap_pct = 0;
  int stall_pct    = 0;

  quad_cell_longitude_regularizer_core dut (
    .clk, .rst,
    .item_valid, .item_stall,
    .lon_0, .lon_1, .lon_2, .lon_3,
    .lat_0, .lat_1, .lat_2, .lat_3,
    .result_valid, .result_stall,
    .out_lon_0, .out_lon_1, .out_lon_2, .out_lon_3,
    .pole_found, .all_corners_pole,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------
  // golden model
  // ---------------------------------------------------------------------
  function automatic longint mag(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // pick lon, lon-p or lon+p, whichever lands strictly closer to anchor;
  // ties keep the earlier choice (no move beats -p beats +p)
  function automatic longint nearest_wrap(input longint p, input longint anchor,
                                          input longint lon);
    longint d, best, down, up, pick;
    d    = lon - anchor;
    best = mag(d);
    down = mag(d - p);
    up   = mag(d + p);
    pick = lon;
    if (down < best) begin
      best = down;
      pick = lon - p;
    end
    if (up < best) begin
      pick = lon + p;
    end
    return pick;
  endfunction

  function automatic cell_out_t regularize_cell(input cell_in_t c);
    cell_out_t r;
    longint    p, anchor, sum, cnt, lo, la;
    longint    lon [4];
    int        pole_idx;
    p        = longint'(cfg_period);
    anchor   = longint'($signed(c.lon[0]));
    sum      = 0;
    cnt      = 0;
    pole_idx = -1;
    // first pass: pull every corner toward corner 0's input longitude
    for (int k = 0; k < 4; k++) begin
      lo = longint'($signed(c.lon[k]));
      la = longint'($signed(c.lat[k]));
      if (cfg_fix) lo = nearest_wrap(p, anchor, lo);
      // pole corner: 4*|lat| == period, the last one found wins
      if (4 * mag(la) == p) pole_idx = k;
      else begin
        sum += lo;
        cnt++;
      end
      lon[k] = lo;
    end
    // pole longitude becomes the mean of the rest, truncated toward zero
    if (cfg_avg && pole_idx >= 0 && cnt != 0) lon[pole_idx] = sum / cnt;
    // second pass re-bases corners 1..3 on corner 0 as it now stands
    if (cfg_fix) begin
      for (int k = 1; k < 4; k++) lon[k] = nearest_wrap(p, lon[0], lon[k]);
    end
    for (int k = 0; k < 4; k++) r.lon[k] = lon[k][31:0];
    r.pole     = (pole_idx >= 0);
    r.all_pole = (cnt == 0);
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------
  function automatic void report_mismatch(input string what, input logic [31:0] want,
                                          input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("mismatch on %s: expected %h, got %h", what, want, got);
  endfunction

  // outputs are read right after the edge, before any NBA lands
  always @(posedge clk) begin : result_check
    cell_out_t        want;
    logic [3:0][31:0] got;
    if (!rst && result_valid && !result_stall) begin
      got = {out_lon_3, out_lon_2, out_lon_1, out_lon_0};
      if (predicted_cells.size() == 0) begin
        report_mismatch("result word with nothing pending", '0, got[0]);
      end else begin
        want = predicted_cells.pop_front();
        for (int k = 0; k < 4; k++) begin
          if (got[k] !== want.lon[k])
            report_mismatch($sformatf("out_lon_%0d", k), want.lon[k], got[k]);
        end
        if (pole_found !== want.pole)
          report_mismatch("pole_found", 32'(want.pole), 32'(pole_found));
        if (all_corners_pole !== want.all_pole)
          report_mismatch("all_corners_pole", 32'(want.all_pole), 32'(all_corners_pole));
      end
    end
  end

  // result side back-pressure: random stall bursts of random length
  initial begin : result_backpressure
    int n;
    forever begin
      @(negedge clk);
      if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
        n = $urandom_range(1, 13);
        result_stall <= 1'b1;
        repeat (n) @(negedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // item side
  // ---------------------------------------------------------------------
  // one word; an optional gap of idle cycles goes in front of it
  task automatic send_cell(input cell_in_t c);
    int gap;
    if (send_gap_pct > 0 && $urandom_range(0, 99) < send_gap_pct) begin
      gap = $urandom_range(1, 13);
      @(negedge clk);
      item_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    item_valid <= 1'b1;
    lon_0 <= c.lon[0];
    lon_1 <= c.lon[1];
    lon_2 <= c.lon[2];
    lon_3 <= c.lon[3];
    lat_0 <= c.lat[0];
    lat_1 <= c.lat[1];
    lat_2 <= c.lat[2];
    lat_3 <= c.lat[3];
    @(posedge clk);
    while (item_stall) @(posedge clk);
    // config is static while words flow, so predict at acceptance
    predicted_cells = {predicted_cells, regularize_cell(c)};
  endtask

  // drop valid, let every pending word come out, then a few spare cycles
  task automatic drain_pipe();
    @(negedge clk);
    item_valid <= 1'b0;
    while (predicted_cells.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 3) @(posedge clk);
  endtask

  function automatic cell_in_t mk_cell(input longint l0, l1, l2, l3, a0, a1, a2, a3);
    cell_in_t c;
    c.lon[0] = 30'(l0);
    c.lon[1] = 30'(l1);
    c.lon[2] = 30'(l2);
    c.lon[3] = 30'(l3);
    c.lat[0] = 30'(a0);
    c.lat[1] = 30'(a1);
    c.lat[2] = 30'(a2);
    c.lat[3] = 30'(a3);
    return c;
  endfunction

  // mostly plausible cells around a random center, spread across the
  // seam, with pole corners mixed in; one in five is raw noise
  function automatic cell_in_t random_cell(input logic [qclr_pkg::PERIOD_W-1:0] period);
    cell_in_t c;
    longint   pl, center, off, lo;
    int       wrap;
    pl = longint'(period);
    if ($urandom_range(0, 99) < 20) begin
      for (int k = 0; k < 4; k++) begin
        c.lon[k] = 30'($urandom);
        c.lat[k] = 30'($urandom);
      end
    end else begin
      center = longint'($signed(30'($urandom)));
      for (int k = 0; k < 4; k++) begin
        off = 0;
        if (pl > 8) off = longint'($urandom_range(0, int'(pl / 4))) - pl / 8;
        lo   = center + off;
        wrap = $urandom_range(0, 3);
        if (wrap == 0) lo += pl;
        if (wrap == 1) lo -= pl;
        c.lon[k] = 30'(lo);
        if (pl % 4 == 0 && $urandom_range(0, 3) == 0)
          c.lat[k] = 30'($urandom_range(0, 1) ? pl / 4 : -(pl / 4));
        else
          c.lat[k] = 30'($urandom);
      end
      // now and then every corner on a pole
      if (pl % 4 == 0 && $urandom_range(0, 19) == 0) begin
        for (int k = 0; k < 4; k++)
          c.lat[k] = 30'($urandom_range(0, 1) ? pl / 4 : -(pl / 4));
      end
    end
    return c;
  endfunction

  // ---------------------------------------------------------------------
  // APB
  // ---------------------------------------------------------------------
  function automatic logic [31:0] shadow_value(input logic [1:0] idx);
    case (idx)
      qclr_pkg::REG_PERIOD:  return 32'(cfg_period);
      qclr_pkg::REG_FIX:     return 32'(cfg_fix);
      qclr_pkg::REG_AVERAGE: return 32'(cfg_avg);
      default:               return '0;
    endcase
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      qclr_pkg::REG_PERIOD:  cfg_period = value[qclr_pkg::PERIOD_W-1:0];
      qclr_pkg::REG_FIX:     cfg_fix    = value[0];
      qclr_pkg::REG_AVERAGE: cfg_avg    = value[0];
      default: ;
    endcase
  endtask

  task automatic check_reg(input logic [1:0] idx);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== shadow_value(idx))
      report_mismatch($sformatf("readback of register %0d", idx), shadow_value(idx), prdata);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // full register update with the pipe empty, then read all three back
  task automatic apply_setting(input logic [31:0] period, input logic fix,
                               input logic avg);
    drain_pipe();
    write_reg(qclr_pkg::REG_PERIOD, period);
    write_reg(qclr_pkg::REG_FIX, 32'(fix));
    write_reg(qclr_pkg::REG_AVERAGE, 32'(avg));
    check_reg(qclr_pkg::REG_PERIOD);
    check_reg(qclr_pkg::REG_FIX);
    check_reg(qclr_pkg::REG_AVERAGE);
  endtask

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------
  task automatic test_reset_values();
    check_reg(qclr_pkg::REG_PERIOD);
    check_reg(qclr_pkg::REG_FIX);
    check_reg(qclr_pkg::REG_AVERAGE);
  endtask

  // reset config: 360 deg period, both features on
  task automatic test_directed_cells();
    // plain cell, nothing to fix
    send_cell(mk_cell(10*DEG, 20*DEG, 30*DEG, 40*DEG, 1*DEG, 2*DEG, 3*DEG, 4*DEG));
    // straddling the seam from either side
    send_cell(mk_cell(179*DEG, -179*DEG, -179*DEG, 179*DEG, 10*DEG, 10*DEG, -10*DEG, -10*DEG));
    send_cell(mk_cell(-179*DEG, 179*DEG, 179*DEG, -179*DEG, 5*DEG, 5*DEG, 6*DEG, 6*DEG));
    // north pole at corner 2, rest across the seam
    send_cell(mk_cell(170*DEG, -170*DEG, 0, 175*DEG, 80*DEG, 80*DEG, 90*DEG, 85*DEG));
    // south pole at corner 0: mean replaces the anchor before pass two
    send_cell(mk_cell(0, 100*DEG, -170*DEG, 170*DEG, -90*DEG, -80*DEG, -80*DEG, -80*DEG));
    // two poles, only the later one is rewritten
    send_cell(mk_cell(20*DEG, 40*DEG, 60*DEG, -7*DEG, 70*DEG, 90*DEG, 70*DEG, -90*DEG));
    // every corner a pole: nothing to average
    send_cell(mk_cell(10*DEG, -170*DEG, 100*DEG, 3, 90*DEG, -90*DEG, 90*DEG, -90*DEG));
    // field extremes
    send_cell(mk_cell(LON_MAX, LON_MAX, LON_MAX, LON_MAX, LON_MIN, LON_MIN, LON_MIN, LON_MIN));
    send_cell(mk_cell(LON_MIN, LON_MIN, LON_MIN, LON_MIN, LON_MAX, LON_MAX, LON_MAX, LON_MAX));
    send_cell(mk_cell(LON_MAX, LON_MIN, LON_MAX, LON_MIN, LON_MIN, LON_MAX, LON_MIN, LON_MAX));
    // exactly half a period away: no move on a tie
    send_cell(mk_cell(0, 180*DEG, -180*DEG, 180*DEG + 1, 0, 1, -1, 2));
    // exactly one period away, and one corner more than a period away
    send_cell(mk_cell(5*DEG, 365*DEG, -355*DEG, -500*DEG, 3, 4, 5, 6));
  endtask

  // the other three switch settings on pole + seam cells
  task automatic test_switch_modes();
    for (int m = 0; m < 3; m++) begin
      apply_setting(32'(qclr_pkg::PERIOD_RESET), m[0], m[1]);
      send_cell(mk_cell(170*DEG, -170*DEG, 0, 175*DEG, 80*DEG, 80*DEG, 90*DEG, 85*DEG));
      send_cell(mk_cell(-179*DEG, 179*DEG, 10*DEG, -100*DEG, -90*DEG, 1, 90*DEG, -90*DEG));
    end
  endtask

  task automatic test_period_extremes();
    // zero period: no shift ever wins and a zero latitude is a pole
    apply_setting(32'd0, 1'b1, 1'b1);
    send_cell(mk_cell(LON_MAX, -5, 7, LON_MIN, 3, 0, 0, -3));
    send_cell(mk_cell(11, -22, 33, -44, 0, 0, 0, 0));
    apply_setting(32'd1, 1'b1, 1'b1);
    send_cell(mk_cell(0, 1, -1, 2, 9, 8, 7, 6));
    // top of the period range, all ones
    apply_setting(32'((64'd1 << qclr_pkg::PERIOD_W) - 1), 1'b1, 1'b1);
    send_cell(mk_cell(LON_MAX, LON_MIN, 0, -1, 1, 2, 3, 4));
    // largest period with exact pole latitudes
    apply_setting(32'd536870908, 1'b1, 1'b1);
    send_cell(mk_cell(LON_MAX, LON_MIN, 100, -100, 134217727, 0, -134217727, 5));
  endtask

  // random phases cycle through periods and all four switch settings;
  // idle pressure comes and goes in stretches, none in the last phase
  task automatic test_random_traffic();
    logic [31:0] period;
    logic [2:0]  ph;
    for (int n = 0; n < RAND_PHASES; n++) begin
      ph = 3'(n);
      case (n)
        0:       period = 32'(qclr_pkg::PERIOD_RESET);
        1:       period = 32'(PERIOD_2PI);
        2:       period = 32'(360) << 8;
        3:       period = 32'($urandom_range(1, 134217727)) << 2;
        4:       period = 32'd536870908;
        5:       period = 32'($urandom_range(1, 536870911));
        6:       period = 32'($urandom_range(1, 64));
        default: period = 32'(qclr_pkg::PERIOD_RESET);
      endcase
      send_gap_pct = 0;
      stall_pct    = 0;
      apply_setting(period, ~(ph[0] ^ ph[2]), ~(ph[1] ^ ph[2]));
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if (n < RAND_PHASES - 1 && (i / 50) % 2 == 0) begin
          send_gap_pct = 15;
          stall_pct    = 12;
        end else begin
          send_gap_pct = 0;
          stall_pct    = 0;
        end
        send_cell(random_cell(cfg_period));
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_values();
    test_directed_cells();
    test_switch_modes();
    test_period_extremes();
    test_random_traffic();
    drain_pipe();
    if (mismatch_count == 0) begin
      $display("PASS quad_cell_longitude_regularizer_core");
    end else begin
      $display("FAIL quad_cell_longitude_regularizer_core");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #4000000;
    $display("FAIL quad_cell_longitude_regularizer_core");
    $finish;
  end

endmodule

`default_nettype wire

// ----- quad_cell_longitude_regularizer_core.f -----
rtl/qclr_pkg.sv
rtl/quad_cell_longitude_regularizer_core.sv
rtl/qclr_checker.sv
verif/tb_top.sv
